### rtl/core/sfgs_pkg.sv
package sfgs_pkg;

  // Geometry
  localparam int NSLOT = 128;
  localparam int AW    = 7;    // slot index
  localparam int CW    = 16;   // saturating counters
  localparam int TW    = 23;   // hits summed over all slots
  localparam int LGW   = 21;   // log2 in Q.16, integer part 5 bits
  localparam int PW    = 44;   // products and dividends
  localparam int DW    = 24;   // divisors
  localparam int RW    = 8;    // rank counters

  localparam logic [CW-1:0] CNT_MAX  = '1;
  localparam logic [14:0]   SHARE_K  = 15'd25600;
  localparam logic [14:0]   SHARE_MAX = 15'h7FFF;
  localparam logic [PW-1:0] ENT_CAP  = PW'(32768);

  // Request codes
  localparam logic [2:0] REQ_MARK  = 3'd0;
  localparam logic [2:0] REQ_DRAW  = 3'd1;
  localparam logic [2:0] REQ_QNUM  = 3'd2;
  localparam logic [2:0] REQ_QRANK = 3'd3;
  localparam logic [2:0] REQ_QENT  = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CFG = 2'd1;
  localparam logic [1:0] ST_NO_DRAW = 2'd2;
  localparam logic [1:0] ST_BAD_OP  = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_LIM  = 2'd2;

  // One slot of statistics
  typedef struct packed {
    logic [CW-1:0] hits;
    logic [CW-1:0] run;
    logic [CW-1:0] lrun;
    logic [CW-1:0] gap;
    logic [CW-1:0] lgap;
  } ent_t;

  // One result
  typedef struct packed {
    logic [1:0]    status;
    logic [CW-1:0] hit_total;
    logic [CW-1:0] run_now;
    logic [CW-1:0] run_best;
    logic [CW-1:0] gap_now;
    logic [CW-1:0] gap_best;
    logic [14:0]   share_percent;
    logic [AW-1:0] hot_number;
    logic [CW-1:0] hot_hits;
    logic [AW-1:0] cold_number;
    logic [CW-1:0] cold_hits;
    logic [15:0]   entropy_scaled;
  } res_t;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + CW'(1);
  endfunction

endpackage

### rtl/core/symbol_frequency_gap_streak_stats_unit.sv
// Draw statistics unit for numbers 0..127.
// Input channel (in_valid_i / in_stall_o, req_type_i, operand_i): a transfer
// takes place when valid is high and stall is low. Marks, end-of-draw and
// clear items give no result; number, rank and entropy queries give one
// result on the output channel (out_valid_o / out_stall_i). The result sits
// in an output register, so the next item is taken while it waits.
// Work per item (all state lives in one statistics memory, one read and
// one write per cycle, read data registered):
//   mark, clear: no memory access, only the seen and valid bits.
//   end of draw: one read-modify-write sweep over the range.
//   number query: the share is formed by the 44-step radix-2 divider.
//   rank query: 18 sweeps of the range (16 bit-by-bit selection
//     sweeps on the hit count, one tie-offset sweep, one pick sweep).
//   entropy query: a serial log2 for each number with nonzero hits
//     (normalize shifts plus 16 squarings), plus two divisions.
// A result moves from the done state into the output register, and the unit
// holds a finished result while the receiver stalls before taking more items.
// Reset (or a clear item) zeroes all statistics at once through per-slot
// valid bits; registers reset to range 0..127 and rank limit 10.
module symbol_frequency_gap_streak_stats_unit
  import sfgs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // APB configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // request channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [2:0]    req_type_i,
  input  logic [6:0]    operand_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    status_o,
  output logic [15:0]   hit_total_o,
  output logic [15:0]   run_now_o,
  output logic [15:0]   run_best_o,
  output logic [15:0]   gap_now_o,
  output logic [15:0]   gap_best_o,
  output logic [14:0]   share_percent_o,
  output logic [6:0]    hot_number_o,
  output logic [15:0]   hot_hits_o,
  output logic [6:0]    cold_number_o,
  output logic [15:0]   cold_hits_o,
  output logic [15:0]   entropy_scaled_o
);

  // State codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DRAW = 5'd1;
  localparam logic [4:0] S_QRD  = 5'd2;
  localparam logic [4:0] S_QDV  = 5'd3;
  localparam logic [4:0] S_DIV  = 5'd4;
  localparam logic [4:0] S_RANK = 5'd5;
  localparam logic [4:0] S_ESUM = 5'd6;
  localparam logic [4:0] S_ERD  = 5'd7;
  localparam logic [4:0] S_EWT  = 5'd8;
  localparam logic [4:0] S_LOG  = 5'd9;
  localparam logic [4:0] S_EMUL = 5'd10;
  localparam logic [4:0] S_EACC = 5'd11;
  localparam logic [4:0] S_TMUL = 5'd12;
  localparam logic [4:0] S_TSUB = 5'd13;
  localparam logic [4:0] S_DONE = 5'd14;

  // Return codes of the log2 unit and the divider
  localparam logic [1:0] LG_C = 2'd0;
  localparam logic [1:0] LG_T = 2'd1;
  localparam logic [1:0] LG_P = 2'd2;
  localparam logic [1:0] DV_S = 2'd0;
  localparam logic [1:0] DV_H = 2'd1;
  localparam logic [1:0] DV_E = 2'd2;

  // ---------------------------------------------------------------------
  // Registers
  logic [4:0]      state_q, state_d;
  logic [AW-1:0]   cfg_low_q, cfg_low_d;
  logic [AW-1:0]   cfg_high_q, cfg_high_d;
  logic [RW-1:0]   cfg_lim_q, cfg_lim_d;
  logic [CW-1:0]   draw_q, draw_d;
  logic [NSLOT-1:0] vld_q, seen_q;
  logic            rd_vld_q, rd_seen_q;
  ent_t            rd_data_q;
  logic [AW-1:0]   rd_idx_q, rd_idx_d;
  logic            iss_q, iss_d;
  logic            pv_q, pv_d;
  logic [AW-1:0]   pa_q, pa_d;
  logic [AW-1:0]   op_q, op_d;
  logic [4:0]      rk_q, rk_d;
  logic [CW-1:0]   hv_q, hv_d, cv_q, cv_d;
  logic [RW-1:0]   cnt_h_q, cnt_h_d, cnt_c_q, cnt_c_d;
  logic [RW-1:0]   tgt_h_q, tgt_h_d, tgt_c_q, tgt_c_d;
  logic [TW-1:0]   t_q, t_d;
  logic [PW-1:0]   acc_q, acc_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [CW-1:0]   c_q, c_d;
  logic [AW-1:0]   en_idx_q, en_idx_d;
  logic [31:0]     lg_m_q, lg_m_d;
  logic [4:0]      lg_e_q, lg_e_d;
  logic [15:0]     lg_f_q, lg_f_d;
  logic [3:0]      lg_k_q, lg_k_d;
  logic            lg_nrm_q, lg_nrm_d;
  logic [1:0]      lg_ret_q, lg_ret_d;
  logic [LGW-1:0]  lg_q, lg_d;
  logic [DW-1:0]   dv_rem_q, dv_rem_d;
  logic [PW-1:0]   dv_quo_q, dv_quo_d;
  logic [DW-1:0]   dv_den_q, dv_den_d;
  logic [5:0]      dv_cnt_q, dv_cnt_d;
  logic [1:0]      dv_ret_q, dv_ret_d;
  logic [LGW-1:0]  h_q, h_d;
  res_t            res_q, res_d;
  res_t            out_q, out_d;
  logic            ov_q, ov_d;

  // Statistics memory
  ent_t            mem [NSLOT];
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  ent_t            wr_data;
  logic            clr_all, seen_set, seen_clr;

  // ---------------------------------------------------------------------
  // Configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_LOW:  prdata = 32'(cfg_low_q);
      REG_HIGH: prdata = 32'(cfg_high_q);
      REG_LIM:  prdata = 32'(cfg_lim_q);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    cfg_low_d  = cfg_low_q;
    cfg_high_d = cfg_high_q;
    cfg_lim_d  = cfg_lim_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_LOW:  cfg_low_d  = pwdata[AW-1:0];
        REG_HIGH: cfg_high_d = pwdata[AW-1:0];
        REG_LIM:  cfg_lim_d  = pwdata[RW-1:0];
        default:  ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Derived values
  ent_t            ent;
  logic            cfg_bad, in_range, op_in;
  logic [RW-1:0]   pop, lim;
  logic            in_xfer, out_free;
  logic            pass_end;
  logic [3:0]      rk_bit;
  logic [CW-1:0]   bit_m, vt_h, vt_c;
  logic [CW-1:0]   run_n, gap_n;
  logic [63:0]     sq;
  logic [32:0]     sq_t;
  logic [15:0]     lg_f_n;
  logic [DW:0]     dv_tmp;
  logic [DW-1:0]   dv_rem_n;
  logic [PW-1:0]   dv_quo_n;
  logic [30:0]     sh_prod;
  logic [36:0]     cl_prod;
  logic [PW-1:0]   ht;
  logic            adv;

  assign ent      = rd_vld_q ? rd_data_q : '0;
  assign cfg_bad  = (cfg_low_q > cfg_high_q) || (cfg_lim_q == '0);
  assign pop      = {1'b0, cfg_high_q} - {1'b0, cfg_low_q} + RW'(1);
  assign lim      = (cfg_lim_q < pop) ? cfg_lim_q : pop;
  assign in_range = (operand_i >= cfg_low_q) && (operand_i <= cfg_high_q);
  assign op_in    = in_range;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !ov_q || !out_stall_i;
  assign pass_end = !iss_q && !pv_q;

  // Rank selection thresholds
  assign rk_bit = 4'(rk_q - 5'd2);
  assign bit_m  = CW'(1) << rk_bit;
  assign vt_h   = hv_q | bit_m;
  assign vt_c   = cv_q | (bit_m - CW'(1));

  // End-of-draw update of one slot
  assign run_n = sat_inc(ent.run);
  assign gap_n = sat_inc(ent.gap);
  always_comb begin
    wr_data = ent;
    if (rd_seen_q) begin
      wr_data.hits = sat_inc(ent.hits);
      wr_data.run  = run_n;
      wr_data.lrun = (run_n > ent.lrun) ? run_n : ent.lrun;
      wr_data.gap  = '0;
    end else begin
      wr_data.run  = '0;
      wr_data.gap  = gap_n;
      wr_data.lgap = (gap_n > ent.lgap) ? gap_n : ent.lgap;
    end
  end

  // log2 squaring step
  assign sq     = 64'(lg_m_q) * 64'(lg_m_q);
  assign sq_t   = sq[63:31];
  assign lg_f_n = sq_t[32] ? (lg_f_q | (16'd1 << lg_k_q)) : lg_f_q;

  // Restoring divider step
  assign dv_tmp   = {dv_rem_q, dv_quo_q[PW-1]};
  assign dv_rem_n = (dv_tmp >= {1'b0, dv_den_q}) ? DW'(dv_tmp - {1'b0, dv_den_q})
                                                 : dv_tmp[DW-1:0];
  assign dv_quo_n = {dv_quo_q[PW-2:0], (dv_tmp >= {1'b0, dv_den_q})};

  assign sh_prod = ent.hits * SHARE_K;
  assign cl_prod = c_q * lg_q;
  assign ht      = (prod_q > acc_q) ? (prod_q - acc_q) : '0;

  // ---------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_d  = state_q;
    draw_d   = draw_q;
    rd_idx_d = rd_idx_q;
    iss_d    = 1'b0;
    pv_d     = 1'b0;
    pa_d     = rd_idx_q;
    op_d     = op_q;
    rk_d     = rk_q;
    hv_d     = hv_q;
    cv_d     = cv_q;
    cnt_h_d  = cnt_h_q;
    cnt_c_d  = cnt_c_q;
    tgt_h_d  = tgt_h_q;
    tgt_c_d  = tgt_c_q;
    t_d      = t_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    c_d      = c_q;
    en_idx_d = en_idx_q;
    lg_m_d   = lg_m_q;
    lg_e_d   = lg_e_q;
    lg_f_d   = lg_f_q;
    lg_k_d   = lg_k_q;
    lg_nrm_d = lg_nrm_q;
    lg_ret_d = lg_ret_q;
    lg_d     = lg_q;
    dv_rem_d = dv_rem_q;
    dv_quo_d = dv_quo_q;
    dv_den_d = dv_den_q;
    dv_cnt_d = dv_cnt_q;
    dv_ret_d = dv_ret_q;
    h_d      = h_q;
    res_d    = res_q;
    out_d    = out_q;
    ov_d     = ov_q && out_stall_i;
    rd_en    = 1'b0;
    rd_addr  = rd_idx_q;
    wr_en    = 1'b0;
    wr_addr  = pa_q;
    clr_all  = 1'b0;
    seen_set = 1'b0;
    seen_clr = 1'b0;
    adv      = 1'b0;

    // shared sweep: one read issued per cycle, read data arrives in the next cycle
    if (state_q == S_DRAW || state_q == S_RANK || state_q == S_ESUM) begin
      rd_en    = iss_q;
      rd_idx_d = rd_idx_q + AW'(1);
      iss_d    = iss_q && (rd_idx_q != cfg_high_q);
      pv_d     = iss_q;
    end

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d  = operand_i;
          res_d = '0;
          case (req_type_i)
            REQ_MARK: seen_set = op_in;
            REQ_DRAW: begin
              draw_d   = sat_inc(draw_q);
              rd_idx_d = cfg_low_q;
              iss_d    = (cfg_low_q <= cfg_high_q);
              state_d  = S_DRAW;
            end
            REQ_CLEAR: begin
              clr_all = 1'b1;
              draw_d  = '0;
            end
            REQ_QNUM, REQ_QRANK, REQ_QENT: begin
              state_d = S_DONE;
              if (cfg_bad) begin
                res_d.status = ST_BAD_CFG;
              end else if (draw_q == '0) begin
                res_d.status = ST_NO_DRAW;
              end else if (req_type_i == REQ_QNUM) begin
                if (!op_in) begin
                  res_d.status = ST_BAD_OP;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = operand_i;
                  state_d = S_QRD;
                end
              end else if (req_type_i == REQ_QRANK) begin
                if ({1'b0, operand_i} >= lim) begin
                  res_d.status = ST_BAD_OP;
                end else begin
                  rk_d     = 5'd17;
                  hv_d     = '0;
                  cv_d     = '0;
                  cnt_h_d  = '0;
                  cnt_c_d  = '0;
                  rd_idx_d = cfg_low_q;
                  iss_d    = 1'b1;
                  state_d  = S_RANK;
                end
              end else if (pop >= RW'(2)) begin
                t_d      = '0;
                acc_d    = '0;
                rd_idx_d = cfg_low_q;
                iss_d    = 1'b1;
                state_d  = S_ESUM;
              end
            end
            default: ;
          endcase
        end
      end

      // read-modify-write sweep over the range
      S_DRAW: begin
        wr_en = pv_q;
        if (pass_end) begin
          seen_clr = 1'b1;
          state_d  = S_IDLE;
        end
      end

      // number query
      S_QRD: begin
        res_d.hit_total = ent.hits;
        res_d.run_now   = ent.run;
        res_d.run_best  = ent.lrun;
        res_d.gap_now   = ent.gap;
        res_d.gap_best  = ent.lgap;
        prod_d          = PW'(sh_prod);
        state_d         = S_QDV;
      end
      S_QDV: begin
        dv_quo_d = prod_q;
        dv_rem_d = '0;
        dv_den_d = DW'(draw_q);
        dv_cnt_d = '0;
        dv_ret_d = DV_S;
        state_d  = S_DIV;
      end

      // one quotient bit per cycle
      S_DIV: begin
        dv_rem_d = dv_rem_n;
        dv_quo_d = dv_quo_n;
        dv_cnt_d = dv_cnt_q + 6'd1;
        if (dv_cnt_q == 6'(PW - 1)) begin
          case (dv_ret_q)
            DV_S: begin
              res_d.share_percent = (dv_quo_n > PW'(SHARE_MAX)) ? SHARE_MAX
                                                                : dv_quo_n[14:0];
              state_d = S_DONE;
            end
            DV_H: begin
              h_d      = dv_quo_n[LGW-1:0];
              lg_m_d   = {23'(pop), 9'd0};
              lg_e_d   = 5'd22;
              lg_f_d   = '0;
              lg_nrm_d = 1'b1;
              lg_ret_d = LG_P;
              state_d  = S_LOG;
            end
            default: begin
              res_d.entropy_scaled = (dv_quo_n > ENT_CAP) ? 16'(ENT_CAP)
                                                           : dv_quo_n[15:0];
              state_d = S_DONE;
            end
          endcase
        end
      end

      // rank query: 16 selection sweeps, a tie-offset sweep, a pick sweep
      S_RANK: begin
        if (pv_q) begin
          if (rk_q >= 5'd2) begin
            if (ent.hits >= vt_h) cnt_h_d = cnt_h_q + RW'(1);
            if (ent.hits <= vt_c) cnt_c_d = cnt_c_q + RW'(1);
          end else if (rk_q == 5'd1) begin
            if (ent.hits > hv_q) cnt_h_d = cnt_h_q + RW'(1);
            if (ent.hits < cv_q) cnt_c_d = cnt_c_q + RW'(1);
          end else begin
            if (ent.hits == hv_q) begin
              if (cnt_h_q == tgt_h_q) begin
                res_d.hot_number = pa_q;
                res_d.hot_hits   = ent.hits;
              end
              cnt_h_d = cnt_h_q + RW'(1);
            end
            if (ent.hits == cv_q) begin
              if (cnt_c_q == tgt_c_q) begin
                res_d.cold_number = pa_q;
                res_d.cold_hits   = ent.hits;
              end
              cnt_c_d = cnt_c_q + RW'(1);
            end
          end
        end
        if (pass_end) begin
          cnt_h_d  = '0;
          cnt_c_d  = '0;
          rd_idx_d = cfg_low_q;
          iss_d    = 1'b1;
          rk_d     = rk_q - 5'd1;
          if (rk_q >= 5'd2) begin
            if (cnt_h_q > {1'b0, op_q}) hv_d = vt_h;
            if (!(cnt_c_q > {1'b0, op_q})) cv_d = cv_q | bit_m;
          end else if (rk_q == 5'd1) begin
            tgt_h_d = {1'b0, op_q} - cnt_h_q;
            tgt_c_d = {1'b0, op_q} - cnt_c_q;
          end else begin
            iss_d   = 1'b0;
            state_d = S_DONE;
          end
        end
      end

      // entropy: total hits first
      S_ESUM: begin
        if (pv_q) t_d = t_q + TW'(ent.hits);
        if (pass_end) begin
          en_idx_d = cfg_low_q;
          state_d  = (t_q == '0) ? S_DONE : S_ERD;
        end
      end
      S_ERD: begin
        rd_en   = 1'b1;
        rd_addr = en_idx_q;
        state_d = S_EWT;
      end
      S_EWT: begin
        c_d = ent.hits;
        if (ent.hits == '0) begin
          adv = 1'b1;
        end else begin
          lg_m_d   = {23'(ent.hits), 9'd0};
          lg_e_d   = 5'd22;
          lg_f_d   = '0;
          lg_nrm_d = 1'b1;
          lg_ret_d = LG_C;
          state_d  = S_LOG;
        end
      end

      // serial log2: normalize, then one squaring per cycle
      S_LOG: begin
        if (lg_nrm_q) begin
          if (lg_m_q[31]) begin
            lg_nrm_d = 1'b0;
            lg_k_d   = 4'd15;
          end else begin
            lg_m_d = {lg_m_q[30:0], 1'b0};
            lg_e_d = lg_e_q - 5'd1;
          end
        end else begin
          lg_m_d = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
          lg_f_d = lg_f_n;
          lg_k_d = lg_k_q - 4'd1;
          if (lg_k_q == 4'd0) begin
            lg_d = {lg_e_q, lg_f_n};
            case (lg_ret_q)
              LG_C: state_d = S_EMUL;
              LG_T: state_d = S_TMUL;
              default: begin
                dv_quo_d = PW'({h_q, 15'd0});
                dv_rem_d = '0;
                dv_den_d = DW'({lg_e_q, lg_f_n});
                dv_cnt_d = '0;
                dv_ret_d = DV_E;
                state_d  = S_DIV;
              end
            endcase
          end
        end
      end

      S_EMUL: begin
        prod_d  = PW'(cl_prod);
        state_d = S_EACC;
      end
      S_EACC: begin
        acc_d = acc_q + prod_q;
        adv   = 1'b1;
      end
      S_TMUL: begin
        prod_d  = t_q * lg_q;
        state_d = S_TSUB;
      end
      S_TSUB: begin
        dv_quo_d = ht;
        dv_rem_d = '0;
        dv_den_d = DW'(t_q);
        dv_cnt_d = '0;
        dv_ret_d = DV_H;
        state_d  = S_DIV;
      end

      // hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // next number of the entropy loop, or log2 of the total
    if (adv) begin
      if (en_idx_q == cfg_high_q) begin
        lg_m_d   = {t_q, 9'd0};
        lg_e_d   = 5'd22;
        lg_f_d   = '0;
        lg_nrm_d = 1'b1;
        lg_ret_d = LG_T;
        state_d  = S_LOG;
      end else begin
        en_idx_d = en_idx_q + AW'(1);
        state_d  = S_ERD;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Memory array
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  // Valid and seen bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      seen_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_seen_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q  <= vld_q[rd_addr];
        rd_seen_q <= seen_q[rd_addr];
      end
      if (clr_all) begin
        vld_q  <= '0;
        seen_q <= '0;
      end else begin
        if (wr_en) vld_q[wr_addr] <= 1'b1;
        if (seen_clr) seen_q <= '0;
        else if (seen_set) seen_q[operand_i] <= 1'b1;
      end
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cfg_low_q  <= '0;
      cfg_high_q <= AW'(127);
      cfg_lim_q  <= RW'(10);
      draw_q     <= '0;
      rd_idx_q   <= '0;
      iss_q      <= 1'b0;
      pv_q       <= 1'b0;
      pa_q       <= '0;
      op_q       <= '0;
      rk_q       <= '0;
      hv_q       <= '0;
      cv_q       <= '0;
      cnt_h_q    <= '0;
      cnt_c_q    <= '0;
      tgt_h_q    <= '0;
      tgt_c_q    <= '0;
      t_q        <= '0;
      acc_q      <= '0;
      prod_q     <= '0;
      c_q        <= '0;
      en_idx_q   <= '0;
      lg_m_q     <= '0;
      lg_e_q     <= '0;
      lg_f_q     <= '0;
      lg_k_q     <= '0;
      lg_nrm_q   <= 1'b0;
      lg_ret_q   <= LG_C;
      lg_q       <= '0;
      dv_rem_q   <= '0;
      dv_quo_q   <= '0;
      dv_den_q   <= '0;
      dv_cnt_q   <= '0;
      dv_ret_q   <= DV_S;
      h_q        <= '0;
      res_q      <= '0;
      out_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cfg_low_q  <= cfg_low_d;
      cfg_high_q <= cfg_high_d;
      cfg_lim_q  <= cfg_lim_d;
      draw_q     <= draw_d;
      rd_idx_q   <= rd_idx_d;
      iss_q      <= iss_d;
      pv_q       <= pv_d;
      pa_q       <= pa_d;
      op_q       <= op_d;
      rk_q       <= rk_d;
      hv_q       <= hv_d;
      cv_q       <= cv_d;
      cnt_h_q    <= cnt_h_d;
      cnt_c_q    <= cnt_c_d;
      tgt_h_q    <= tgt_h_d;
      tgt_c_q    <= tgt_c_d;
      t_q        <= t_d;
      acc_q      <= acc_d;
      prod_q     <= prod_d;
      c_q        <= c_d;
      en_idx_q   <= en_idx_d;
      lg_m_q     <= lg_m_d;
      lg_e_q     <= lg_e_d;
      lg_f_q     <= lg_f_d;
      lg_k_q     <= lg_k_d;
      lg_nrm_q   <= lg_nrm_d;
      lg_ret_q   <= lg_ret_d;
      lg_q       <= lg_d;
      dv_rem_q   <= dv_rem_d;
      dv_quo_q   <= dv_quo_d;
      dv_den_q   <= dv_den_d;
      dv_cnt_q   <= dv_cnt_d;
      dv_ret_q   <= dv_ret_d;
      h_q        <= h_d;
      res_q      <= res_d;
      out_q      <= out_d;
      ov_q       <= ov_d;
    end
  end

  // Outputs
  assign out_valid_o      = ov_q;
  assign status_o         = out_q.status;
  assign hit_total_o      = out_q.hit_total;
  assign run_now_o        = out_q.run_now;
  assign run_best_o       = out_q.run_best;
  assign gap_now_o        = out_q.gap_now;
  assign gap_best_o       = out_q.gap_best;
  assign share_percent_o  = out_q.share_percent;
  assign hot_number_o     = out_q.hot_number;
  assign hot_hits_o       = out_q.hot_hits;
  assign cold_number_o    = out_q.cold_number;
  assign cold_hits_o      = out_q.cold_hits;
  assign entropy_scaled_o = out_q.entropy_scaled;

  // ---------------------------------------------------------------------
  // Checks
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished query");

  a_wr_in_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_DRAW))
    else $error("memory write outside end-of-draw sweep");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dv_cnt_q < 6'(PW)))
    else $error("divider ran past its last step");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfgs_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 400;

  logic          clk_i;
  logic          rst_ni;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [3:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [2:0]    req_type_i;
  logic [6:0]    operand_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [1:0]    status_o;
  logic [15:0]   hit_total_o;
  logic [15:0]   run_now_o;
  logic [15:0]   run_best_o;
  logic [15:0]   gap_now_o;
  logic [15:0]   gap_best_o;
  logic [14:0]   share_percent_o;
  logic [6:0]    hot_number_o;
  logic [15:0]   hot_hits_o;
  logic [6:0]    cold_number_o;
  logic [15:0]   cold_hits_o;
  logic [15:0]   entropy_scaled_o;

  symbol_frequency_gap_streak_stats_unit dut (.*);

  // Shadow copy of the statistics and registers
  logic [CW-1:0] sh_hits [NSLOT];
  logic [CW-1:0] sh_run  [NSLOT];
  logic [CW-1:0] sh_lrun [NSLOT];
  logic [CW-1:0] sh_gap  [NSLOT];
  logic [CW-1:0] sh_lgap [NSLOT];
  logic          sh_seen [NSLOT];
  logic [CW-1:0] sh_draws;
  logic [6:0]    cfg_low;
  logic [6:0]    cfg_high;
  logic [7:0]    cfg_lim;

  res_t stats_due[$];
  int   n_errors;
  int   n_items;
  int   n_results;
  int   n_queries [8];
  int   idle_cycles;
  int   burst_left;
  int   stall_pct;
  bit   hold_req;
  int   hold_cnt;
  bit   gaps_on;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [CW-1:0] cnt_up(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // log2 in Q.16 by mantissa squaring
  function automatic longint unsigned log2_q16(input longint unsigned x);
    int unsigned msb;
    longint unsigned mant;
    longint unsigned frac;
    msb = 0;
    frac = 0;
    while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
    mant = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
    for (int k = 15; k >= 0; k--) begin
      mant = (mant * mant) >> 31;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac = frac | (64'd1 << k);
      end
    end
    return (longint'(msb) << 16) | frac;
  endfunction

  function automatic longint unsigned entropy_q15();
    longint unsigned pop, tot, acc, ht, h, r;
    pop = cfg_high - cfg_low + 1;
    tot = 0;
    acc = 0;
    if (pop < 2) return 0;
    for (int n = cfg_low; n <= cfg_high; n++) tot += sh_hits[n];
    if (tot == 0) return 0;
    for (int n = cfg_low; n <= cfg_high; n++)
      if (sh_hits[n] != 0) acc += sh_hits[n] * log2_q16(sh_hits[n]);
    ht = tot * log2_q16(tot);
    ht = (ht > acc) ? ht - acc : 0;
    h = ht / tot;
    r = (h << 15) / log2_q16(pop);
    return (r > 32768) ? 32768 : r;
  endfunction

  function automatic int slot_order(input int n, input bit hot);
    int pos;
    bit ahead;
    pos = 0;
    for (int m = cfg_low; m <= cfg_high; m++) begin
      ahead = hot ? (sh_hits[m] > sh_hits[n]) : (sh_hits[m] < sh_hits[n]);
      if (ahead || (sh_hits[m] == sh_hits[n] && m < n)) pos++;
    end
    return pos;
  endfunction

  function automatic void clear_stats();
    for (int n = 0; n < NSLOT; n++) begin
      sh_hits[n] = '0; sh_run[n] = '0; sh_lrun[n] = '0;
      sh_gap[n] = '0; sh_lgap[n] = '0; sh_seen[n] = 1'b0;
    end
    sh_draws = '0;
  endfunction

  // Apply one item to the shadow state; queue a result for queries
  function automatic void track_item(input logic [2:0] req, input logic [6:0] op);
    res_t r;
    longint unsigned share, pop, lim;
    r = '0;
    case (req)
      REQ_MARK: begin
        if (op >= cfg_low && op <= cfg_high) sh_seen[op] = 1'b1;
        return;
      end
      REQ_DRAW: begin
        sh_draws = cnt_up(sh_draws);
        for (int n = cfg_low; n <= cfg_high; n++) begin
          if (sh_seen[n]) begin
            sh_hits[n] = cnt_up(sh_hits[n]);
            sh_run[n] = cnt_up(sh_run[n]);
            if (sh_run[n] > sh_lrun[n]) sh_lrun[n] = sh_run[n];
            sh_gap[n] = '0;
          end else begin
            sh_run[n] = '0;
            sh_gap[n] = cnt_up(sh_gap[n]);
            if (sh_gap[n] > sh_lgap[n]) sh_lgap[n] = sh_gap[n];
          end
        end
        for (int n = 0; n < NSLOT; n++) sh_seen[n] = 1'b0;
        return;
      end
      REQ_CLEAR: begin
        clear_stats();
        return;
      end
      REQ_QNUM, REQ_QRANK, REQ_QENT: ;
      default: return;
    endcase
    n_queries[req]++;
    if (cfg_low > cfg_high || cfg_lim == 0) r.status = ST_BAD_CFG;
    else if (sh_draws == 0) r.status = ST_NO_DRAW;
    else if (req == REQ_QNUM) begin
      if (op < cfg_low || op > cfg_high) r.status = ST_BAD_OP;
      else begin
        share = (longint'(sh_hits[op]) * 25600) / sh_draws;
        r.hit_total = sh_hits[op];
        r.run_now = sh_run[op];
        r.run_best = sh_lrun[op];
        r.gap_now = sh_gap[op];
        r.gap_best = sh_lgap[op];
        r.share_percent = (share > 32767) ? 15'h7FFF : share[14:0];
      end
    end else if (req == REQ_QRANK) begin
      pop = cfg_high - cfg_low + 1;
      lim = (cfg_lim < pop) ? cfg_lim : pop;
      if (op >= lim) r.status = ST_BAD_OP;
      else begin
        for (int n = cfg_low; n <= cfg_high; n++) begin
          if (slot_order(n, 1'b1) == op) begin
            r.hot_number = n[6:0];
            r.hot_hits = sh_hits[n];
          end
          if (slot_order(n, 1'b0) == op) begin
            r.cold_number = n[6:0];
            r.cold_hits = sh_hits[n];
          end
        end
      end
    end else begin
      r.entropy_scaled = 16'(entropy_q15());
    end
    stats_due.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (stats_due.size() == 0) begin
        report_mismatch("results without a pending query", 1, 0);
      end else begin
        want = stats_due.pop_front();
        if (status_o != want.status) report_mismatch("status", status_o, want.status);
        if (hit_total_o != want.hit_total)
          report_mismatch("hit_total", hit_total_o, want.hit_total);
        if (run_now_o != want.run_now) report_mismatch("run_now", run_now_o, want.run_now);
        if (run_best_o != want.run_best)
          report_mismatch("run_best", run_best_o, want.run_best);
        if (gap_now_o != want.gap_now) report_mismatch("gap_now", gap_now_o, want.gap_now);
        if (gap_best_o != want.gap_best)
          report_mismatch("gap_best", gap_best_o, want.gap_best);
        if (share_percent_o != want.share_percent)
          report_mismatch("share_percent", share_percent_o, want.share_percent);
        if (hot_number_o != want.hot_number)
          report_mismatch("hot_number", hot_number_o, want.hot_number);
        if (hot_hits_o != want.hot_hits)
          report_mismatch("hot_hits", hot_hits_o, want.hot_hits);
        if (cold_number_o != want.cold_number)
          report_mismatch("cold_number", cold_number_o, want.cold_number);
        if (cold_hits_o != want.cold_hits)
          report_mismatch("cold_hits", cold_hits_o, want.cold_hits);
        if (entropy_scaled_o != want.entropy_scaled)
          report_mismatch("entropy_scaled", entropy_scaled_o, want.entropy_scaled);
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 600;
      hold_req <= 1'b0;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= (hold_cnt > 1);
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("symbol_frequency_gap_streak_stats_unit test failed");
      $finish;
    end
  end

  // Send one request; valid stays up between back-to-back items
  task automatic send_item(input logic [2:0] req, input logic [6:0] op);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    operand_i <= op;
    do @(posedge clk_i); while (in_stall_o);
    track_item(req, op);
    n_items++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic rest_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait until every query is answered and the unit is idle
  task automatic drain();
    rest_input();
    wait (stats_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LOW:  cfg_low = val[6:0];
      REG_HIGH: cfg_high = val[6:0];
      default:  cfg_lim = val[7:0];
    endcase
  endtask

  task automatic set_config(input int lo, input int hi, input int lim);
    drain();
    reg_write(REG_LOW, lo);
    reg_write(REG_HIGH, hi);
    reg_write(REG_LIM, lim);
  endtask

  // One draw of a few numbers, mostly inside the range
  task automatic one_draw(input int marks);
    for (int i = 0; i < marks; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(REQ_MARK, 7'($urandom_range(0, 127)));
      else send_item(REQ_MARK, 7'($urandom_range(cfg_low, cfg_high)));
    end
    send_item(REQ_DRAW, 7'd0);
  endtask

  task automatic test_before_draws();
    send_item(REQ_QNUM, 7'd0);
    send_item(REQ_QRANK, 7'd0);
    send_item(REQ_QENT, 7'd0);
  endtask

  task automatic test_directed();
    // marks of 0, 127 and 0x55 over three draws, then unknown codes, queries and a clear
    send_item(REQ_MARK, 7'd0);
    send_item(REQ_MARK, 7'd127);
    send_item(REQ_MARK, 7'd127);
    send_item(REQ_DRAW, 7'd0);
    send_item(REQ_MARK, 7'd127);
    send_item(REQ_MARK, 7'h55);
    send_item(REQ_DRAW, 7'h2A);
    send_item(REQ_DRAW, 7'd0);
    send_item(3'd6, 7'h7F);
    send_item(3'd7, 7'h2A);
    send_item(REQ_QNUM, 7'd127);
    send_item(REQ_QNUM, 7'd0);
    send_item(REQ_QNUM, 7'h55);
    send_item(REQ_QNUM, 7'h2A);
    send_item(REQ_QRANK, 7'd0);
    send_item(REQ_QRANK, 7'd9);
    send_item(REQ_QRANK, 7'd10);
    send_item(REQ_QRANK, 7'd127);
    send_item(REQ_QENT, 7'd0);
    send_item(REQ_CLEAR, 7'd0);
    send_item(REQ_QNUM, 7'd127);
  endtask

  task automatic test_bad_config();
    set_config(90, 20, 10);
    send_item(REQ_MARK, 7'd50);
    send_item(REQ_DRAW, 7'd0);
    send_item(REQ_QNUM, 7'd50);
    send_item(REQ_QENT, 7'd0);
    set_config(0, 127, 0);
    send_item(REQ_QRANK, 7'd0);
  endtask

  task automatic test_single_slot();
    set_config(64, 64, 128);
    repeat (3) one_draw(2);
    send_item(REQ_QENT, 7'd0);
    send_item(REQ_QRANK, 7'd0);
    send_item(REQ_QRANK, 7'd1);
    send_item(REQ_QNUM, 7'd63);
    send_item(REQ_QNUM, 7'd64);
  endtask

  task automatic test_backpressure();
    set_config(10, 40, 1);
    repeat (4) one_draw(6);
    drain();
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) send_item(REQ_QNUM, 7'($urandom_range(5, 45)));
  endtask

  task automatic test_random(input int target);
    int pick, lo, hi;
    while (n_items < target) begin
      // occasionally change the setup
      if ($urandom_range(0, 99) < 5) begin
        lo = $urandom_range(0, 100);
        hi = $urandom_range(lo, 127);
        case ($urandom_range(0, 3))
          0: set_config(0, 127, 128);
          1: set_config(lo, hi, 1);
          2: set_config(lo, hi, 255);
          default: set_config(lo, hi, $urandom_range(1, 128));
        endcase
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(10, 70);
      pick = $urandom_range(0, 99);
      if (pick < 60) one_draw($urandom_range(0, 8));
      else if (pick < 78) send_item(REQ_QNUM, 7'($urandom_range(0, 127)));
      else if (pick < 86) send_item(REQ_QRANK, $urandom_range(0, 3) == 0 ?
                                    7'($urandom_range(0, 127)) :
                                    7'($urandom_range(0, 12)));
      else if (pick < 91) send_item(REQ_QENT, 7'($urandom));
      else if (pick < 93) send_item(REQ_CLEAR, 7'($urandom));
      else if (pick < 96) send_item(3'($urandom_range(6, 7)), 7'($urandom));
      else send_item(REQ_MARK, 7'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    req_type_i = '0;
    operand_i = '0;
    out_stall_i = 1'b0;
    n_errors = 0;
    n_items = 0;
    n_results = 0;
    idle_cycles = 0;
    burst_left = 0;
    stall_pct = 30;
    hold_req = 1'b0;
    hold_cnt = 0;
    gaps_on = 1'b1;
    for (int i = 0; i < 8; i++) n_queries[i] = 0;
    clear_stats();
    cfg_low = 7'd0;
    cfg_high = 7'd127;
    cfg_lim = 8'd10;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_before_draws();
    test_directed();
    test_bad_config();
    test_single_slot();
    test_backpressure();
    set_config(0, 127, 128);
    test_random(850);
    drain();

    $display("covered %0d requests: %0d number, %0d rank, %0d entropy queries",
             n_items, n_queries[REQ_QNUM], n_queries[REQ_QRANK], n_queries[REQ_QENT]);
    $display("checked %0d results across range and rank-limit settings", n_results);
    if (n_errors == 0 && stats_due.size() == 0) begin
      $display("symbol_frequency_gap_streak_stats_unit test passed");
    end else begin
      $display("symbol_frequency_gap_streak_stats_unit test failed");
    end
    $finish;
  end

endmodule
